FILE: sv/htfe_pkg.sv
// Shared types, constants and helpers for the header/trailer frame extractor.
package htfe_pkg;

    localparam logic [31:0] HDR_WORD = 32'hA0FF_FFA0;
    localparam logic [31:0] TRL_WORD = 32'hB0B0_0A0D;

    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
    localparam logic [23:0] TIMEOUT_RESET = 24'd1000;
    localparam logic [15:0] HDR_LEN       = 16'd4;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_FRAME    = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_TIMEOUT  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_MAX_LEN = 1'b0,
        REG_TIMEOUT = 1'b1
    } reg_idx_t;

    // One descriptor from the step logic to the output stage.
    // hdr set: four header beats follow, other payload fields unused.
    typedef struct packed {
        logic        valid;
        logic        hdr;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        status_t     status;
        logic        last;
    } res_desc_t;

    // Header byte for beat k, oldest byte first.
    function automatic logic [7:0] hdr_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = HDR_WORD[31:24];
            2'd1:    b = HDR_WORD[23:16];
            2'd2:    b = HDR_WORD[15:8];
            2'd3:    b = HDR_WORD[7:0];
            default: b = HDR_WORD[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: sv/htfe_core.sv
// Frame state and per-item step logic: hunt, header/trailer match, limits.
module htfe_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  htfe_pkg::cmd_t      cmd,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         max_frame_len,
    input  logic [23:0]         timeout_ticks,
    output htfe_pkg::res_desc_t desc
);

    logic [31:0] window_reg, window_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] count_reg, count_next;
    logic [23:0] ticks_reg, ticks_next;

    logic [31:0] shifted;
    logic [23:0] ticks_inc;

    assign shifted   = {window_reg[23:0], rx_byte};
    assign ticks_inc = ticks_reg + 24'd1;

    always_comb begin
        window_next   = window_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        ticks_next    = ticks_reg;
        desc            = '0;
        desc.status     = htfe_pkg::ST_FRAME;
        desc.byte_index = count_reg;

        case (cmd)
            htfe_pkg::CMD_TICK: begin
                if (in_frame_reg) begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_ticks) begin
                        desc.valid  = 1'b1;
                        desc.status = htfe_pkg::ST_TIMEOUT;
                        desc.last   = 1'b1;
                        window_next   = '0;
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        ticks_next    = '0;
                    end
                end
            end
            htfe_pkg::CMD_BYTE: begin
                window_next = shifted;
                if (!in_frame_reg) begin
                    if (shifted == htfe_pkg::HDR_WORD) begin
                        desc.valid = 1'b1;
                        if (max_frame_len < htfe_pkg::HDR_LEN) begin
                            desc.status     = htfe_pkg::ST_OVERFLOW;
                            desc.last       = 1'b1;
                            desc.byte_index = '0;
                            window_next = '0;
                        end else begin
                            desc.hdr      = 1'b1;
                            in_frame_next = 1'b1;
                            count_next    = htfe_pkg::HDR_LEN;
                            ticks_next    = '0;
                        end
                    end
                end else if (count_reg >= max_frame_len) begin
                    desc.valid  = 1'b1;
                    desc.status = htfe_pkg::ST_OVERFLOW;
                    desc.last   = 1'b1;
                    window_next   = '0;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    ticks_next    = '0;
                end else if (shifted == htfe_pkg::TRL_WORD) begin
                    desc.valid     = 1'b1;
                    desc.data_byte = rx_byte;
                    desc.last      = 1'b1;
                    window_next   = '0;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    ticks_next    = '0;
                end else begin
                    desc.valid     = 1'b1;
                    desc.data_byte = rx_byte;
                    count_next     = count_reg + 16'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            ticks_reg    <= '0;
        end else if (accept) begin
            window_reg   <= window_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

FILE: sv/htfe_out.sv
// Result register; expands a header descriptor into four header beats.
module htfe_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  htfe_pkg::res_desc_t desc,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    htfe_pkg::res_desc_t desc_reg;
    logic                valid_reg;
    logic [1:0]          beat_reg, beat_next;
    logic                take, done;

    assign take = valid_reg & m_tready;
    assign done = take & (!desc_reg.hdr | (beat_reg == 2'd3));
    assign free = !valid_reg | done;

    always_comb begin
        beat_next = beat_reg;
        if (load && free)
            beat_next = '0;
        else if (take)
            beat_next = beat_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            beat_reg <= beat_next;
            if (free)
                valid_reg <= load & desc.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free)
            desc_reg <= desc;
    end

    assign m_tvalid = valid_reg;

    always_comb begin
        if (desc_reg.hdr) begin
            m_tdata = {14'd0, beat_reg, htfe_pkg::hdr_byte(beat_reg)};
            m_tuser = htfe_pkg::ST_FRAME;
            m_tlast = 1'b0;
        end else begin
            m_tdata = {desc_reg.byte_index, desc_reg.data_byte};
            m_tuser = desc_reg.status;
            m_tlast = desc_reg.last;
        end
    end

endmodule

FILE: sv/header_trailer_frame_extractor_top.sv
// Top level of the header/trailer frame extractor.
// A result transfer, if the input produces one, is registered and offered in the cycle after its input transfer.
// Throughput: one input per cycle while the result register can take the step's output; a header
//   item occupies the result register for four beats, and the input side stalls until its last beat leaves.
// Reset (aresetn low, synchronous): hunting, window/counters cleared,
//   max_frame_len 65535, timeout_ticks 1000, no result pending.
module header_trailer_frame_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,   // 0 max_frame_len, 1 timeout_ticks
    input  logic [23:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    input  logic        s_tuser,     // [0] cmd (0 byte, 1 ms tick)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [7:0] data_byte, [23:8] byte_index
    output logic [1:0]  m_tuser,     // [1:0] status
    output logic        m_tlast      // last
);

    logic [15:0] max_len_reg;
    logic [23:0] timeout_reg;

    // Config registers; the user must write them only while idle, the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= htfe_pkg::MAX_LEN_RESET;
            timeout_reg <= htfe_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (htfe_pkg::reg_idx_t'(cfg_index))
                htfe_pkg::REG_MAX_LEN: max_len_reg <= cfg_wdata[15:0];
                htfe_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                accept;
    logic                out_free;
    htfe_pkg::res_desc_t desc;

    // Input transfer is taken whenever the result register can take the
    // step's output (empty, or its last beat leaves this cycle).
    assign s_tready = out_free;
    assign accept   = s_tvalid & s_tready;

    htfe_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .cmd           (htfe_pkg::cmd_t'(s_tuser)),
        .rx_byte       (s_tdata),
        .max_frame_len (max_len_reg),
        .timeout_ticks (timeout_reg),
        .desc          (desc)
    );

    htfe_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .desc     (desc),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the header/trailer frame extractor top level.
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 5000;   // cycles without any transfer
    localparam int TAIL_CYCLES = 8;

    // One expected result transfer.
    typedef struct packed {
        logic [7:0]        data_byte;
        logic [15:0]       byte_index;
        htfe_pkg::status_t status;
        logic              last;
    } frame_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    htfe_pkg::reg_idx_t cfg_index = htfe_pkg::REG_MAX_LEN;
    logic [23:0]        cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tuser = htfe_pkg::CMD_BYTE;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    // Local copy of the extractor state and registers.
    logic [15:0] max_len;
    logic [23:0] tmo_ticks;
    logic [31:0] window;
    logic        in_frame;
    logic [15:0] frame_len;
    logic [23:0] tick_cnt;

    frame_beat_t pending_beats[$];
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;

    header_trailer_frame_extractor_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Frame tracker
    // ---------------------------------------------------------------
    task automatic push_beat(input logic [7:0] d, input logic [15:0] idx,
                             input htfe_pkg::status_t st, input logic lst);
        frame_beat_t fb;
        fb.data_byte  = d;
        fb.byte_index = idx;
        fb.status     = st;
        fb.last       = lst;
        pending_beats.push_back(fb);
    endtask

    task automatic rehunt();
        window    = '0;
        in_frame  = 1'b0;
        frame_len = '0;
        tick_cnt  = '0;
    endtask

    // Advance the tracked state by one accepted input transfer.
    task automatic track_frame(input htfe_pkg::cmd_t c, input logic [7:0] b);
        int k;
        if (c == htfe_pkg::CMD_TICK) begin
            // ticks only count inside a frame
            if (!in_frame) return;
            tick_cnt = tick_cnt + 24'd1;
            if (tick_cnt >= tmo_ticks) begin
                push_beat(8'h00, frame_len, htfe_pkg::ST_TIMEOUT, 1'b1);
                rehunt();
            end
            return;
        end
        window = {window[23:0], b};
        if (!in_frame) begin
            if (window != htfe_pkg::HDR_WORD) return;
            if (max_len < htfe_pkg::HDR_LEN) begin
                // header alone would not fit
                push_beat(8'h00, 16'd0, htfe_pkg::ST_OVERFLOW, 1'b1);
                rehunt();
                return;
            end
            for (k = 0; k < 4; k++)
                push_beat(window[31 - 8 * k -: 8], 16'(k), htfe_pkg::ST_FRAME, 1'b0);
            in_frame  = 1'b1;
            frame_len = htfe_pkg::HDR_LEN;
            tick_cnt  = '0;
            return;
        end
        if (frame_len >= max_len) begin
            // byte is dropped
            push_beat(8'h00, frame_len, htfe_pkg::ST_OVERFLOW, 1'b1);
            rehunt();
        end else if (window == htfe_pkg::TRL_WORD) begin
            push_beat(b, frame_len, htfe_pkg::ST_FRAME, 1'b1);
            rehunt();
        end else begin
            push_beat(b, frame_len, htfe_pkg::ST_FRAME, 1'b0);
            frame_len = frame_len + 16'd1;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random backpressure, checking, watchdog
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(input string name, input int exp_v,
                                        input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        frame_beat_t fb;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result transfer: data 0x%0h index %0d",
                       m_tdata[7:0], m_tdata[23:8]);
                err_count++;
            end else begin
                fb = pending_beats.pop_front();
                check_field("data_byte", fb.data_byte, m_tdata[7:0]);
                check_field("byte_index", fb.byte_index, m_tdata[23:8]);
                check_field("status", fb.status, m_tuser);
                check_field("last", fb.last, m_tlast);
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Send one item; tvalid stays up after the transfer until the next
    // call decides on a gap.
    task automatic send_item(input htfe_pkg::cmd_t c, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_frame(c, b);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(htfe_pkg::CMD_BYTE, b);
    endtask

    // tdata is don't-care on a tick, so drive it with noise
    task automatic send_tick();
        send_item(htfe_pkg::CMD_TICK, 8'($urandom_range(255)));
    endtask

    // Four bytes, oldest first.
    task automatic send_word(input logic [31:0] w);
        int k;
        for (k = 3; k >= 0; k--)
            send_byte(w[8 * k +: 8]);
    endtask

    // Let every expected result drain before touching the registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input htfe_pkg::reg_idx_t r, input logic [23:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (r == htfe_pkg::REG_MAX_LEN)
            max_len = v[15:0];
        else
            tmo_ticks = v;
    endtask

    // Upper bits of the length write are junk that the block must drop.
    task automatic set_limits(input logic [15:0] len, input logic [23:0] tmo);
        settle();
        write_cfg(htfe_pkg::REG_MAX_LEN, {8'($urandom_range(255)), len});
        write_cfg(htfe_pkg::REG_TIMEOUT, tmo);
    endtask

    // Bytes biased toward header and trailer values.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return htfe_pkg::HDR_WORD[31:24];
            1:       return htfe_pkg::HDR_WORD[23:16];
            2:       return htfe_pkg::TRL_WORD[31:24];
            3:       return htfe_pkg::TRL_WORD[15:8];
            4:       return htfe_pkg::TRL_WORD[7:0];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly well-formed frames with random payload, some noise.
    task automatic random_frames(input int n_items);
        int sent;
        int k;
        int n;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                n = $urandom_range(2);
                for (k = 0; k < n; k++) send_byte(pick_byte());
                send_word(htfe_pkg::HDR_WORD);
                sent += n + 4;
                n = $urandom_range(24);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(9) == 0)
                        send_tick();
                    else
                        send_byte(8'($urandom_range(255)));
                end
                sent += n;
                // occasionally abandon the frame with no trailer
                if ($urandom_range(9) < 8) begin
                    send_word(htfe_pkg::TRL_WORD);
                    sent += 4;
                end
            end else begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(4) == 0)
                        send_tick();
                    else
                        send_byte(pick_byte());
                end
                sent += n;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Tick while hunting, header, payload extremes, tick in frame, trailer.
    task automatic test_frame_passthrough();
        send_tick();
        send_word(htfe_pkg::HDR_WORD);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_tick();
        send_word(htfe_pkg::TRL_WORD);
    endtask

    // Timeout on first tick, overflow on a full frame, header too long.
    task automatic test_error_cases();
        set_limits(16'd5, 24'd0);
        send_word(htfe_pkg::HDR_WORD);
        send_byte(8'h55);
        send_tick();
        send_word(htfe_pkg::HDR_WORD);
        send_byte(8'h12);
        send_byte(8'h34);
        set_limits(16'd3, 24'd1000);
        send_word(htfe_pkg::HDR_WORD);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall,
                                       input logic [15:0] len_a,
                                       input logic [23:0] tmo_a,
                                       input logic [15:0] len_b,
                                       input logic [23:0] tmo_b);
        settle();
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        set_limits(len_a, tmo_a);
        random_frames(25);
        set_limits(len_b, tmo_b);
        random_frames(25);
    endtask

    initial begin
        max_len   = htfe_pkg::MAX_LEN_RESET;
        tmo_ticks = htfe_pkg::TIMEOUT_RESET;
        rehunt();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_frame_passthrough();
        test_error_cases();
        test_random_traffic(0, 0, 16'hFFFF, 24'hFFFFFF, 16'd20, 24'd1000);
        test_random_traffic(57, 0, 16'd0, 24'd5, 16'd4, 24'd0);
        test_random_traffic(0, 57, 16'd12, 24'd3, 16'hFFFF, 24'd1);
        test_random_traffic(26, 26, 16'd30, 24'hFFFFFF, 16'd7, 24'd8);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/htfe_pkg.sv
sv/htfe_core.sv
sv/htfe_out.sv
sv/header_trailer_frame_extractor_top.sv
sim/tb.sv
